FILE: src/stq_pkg.sv
package stq_pkg;

   // Event slots and the widths that follow from them
   localparam int ID_W = 5;
   localparam int SLOTS = 1 << ID_W;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DATA_W = 32;
   localparam int CFG_W = 31;

   // Operation codes of the request beat
   localparam logic [2:0] OP_SET = 3'd0;
   localparam logic [2:0] OP_CANCEL = 3'd1;
   localparam logic [2:0] OP_PROGRESS = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_CONSUME = 3'd4;
   localparam logic [2:0] OP_FORCE_EXIT = 3'd5;

   // Configuration register indexes and reset values
   localparam logic REG_MAX_WINDOW = 1'b0;
   localparam logic REG_CLOCKS_PER_MS = 1'b1;
   localparam logic [CFG_W-1:0] MAX_WINDOW_RESET = CFG_W'(1024);
   localparam logic [CFG_W-1:0] CLOCKS_PER_MS_RESET = '0;

   // Shared arithmetic unit operations
   localparam logic [1:0] ALU_ADD = 2'd0;
   localparam logic [1:0] ALU_SUB = 2'd1;
   localparam logic [1:0] ALU_MUL = 2'd2;

   // Order list commands
   localparam logic [2:0] LST_NOP = 3'd0;
   localparam logic [2:0] LST_FIND = 3'd1;
   localparam logic [2:0] LST_REMOVE = 3'd2;
   localparam logic [2:0] LST_INSERT = 3'd3;
   localparam logic [2:0] LST_WRITE = 3'd4;
   localparam logic [2:0] LST_COUNT = 3'd5;

   typedef struct packed {
      logic [2:0]       op;
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] idx;
   } lst_cmd_type;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] count;
   } lst_stat_type;

endpackage

FILE: src/stq_alu.sv
module stq_alu (
   input  logic [1:0]                  op,
   input  logic [stq_pkg::DATA_W-1:0]  opa,
   input  logic [stq_pkg::DATA_W-1:0]  opb,
   output logic [stq_pkg::DATA_W-1:0]  result,
   output logic                        less
);

   logic [stq_pkg::DATA_W:0] diff;

   // Signed compare from a sign-extended subtraction
   assign diff = {opa[stq_pkg::DATA_W-1], opa} - {opb[stq_pkg::DATA_W-1], opb};
   assign less = diff[stq_pkg::DATA_W];

   // Select the wrapped result
   always_comb begin
      case (op)
         stq_pkg::ALU_ADD: result = opa + opb;
         stq_pkg::ALU_SUB: result = diff[stq_pkg::DATA_W-1:0];
         stq_pkg::ALU_MUL: result = opa * opb;
         default:          result = '0;
      endcase
   end

endmodule

FILE: src/stq_due_mem.sv
module stq_due_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [stq_pkg::ID_W-1:0]    wr_addr,
   input  logic [stq_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [stq_pkg::ID_W-1:0]    rd_addr,
   output logic [stq_pkg::DATA_W-1:0]  rd_data
);

   logic [stq_pkg::DATA_W-1:0] due_mem [stq_pkg::SLOTS];
   logic [stq_pkg::DATA_W-1:0] rd_data_ff;

   // Write one due time, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         due_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= due_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/stq_list.sv
module stq_list (
   input  logic                      clock,
   input  logic                      reset,
   input  stq_pkg::lst_cmd_type      cmd,
   input  logic [stq_pkg::ID_W-1:0]  rd_idx,
   output logic [stq_pkg::ID_W-1:0]  rd_id,
   output stq_pkg::lst_stat_type     stat
);

   logic [stq_pkg::ID_W-1:0]  entry_ff [stq_pkg::SLOTS];
   logic [stq_pkg::ID_W-1:0]  entry_in [stq_pkg::SLOTS];
   logic [stq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      hit_ff, hit_in;
   logic [stq_pkg::ID_W-1:0]  pos_ff, pos_in;
   logic [stq_pkg::SLOTS-1:0] match;
   logic [stq_pkg::ID_W-1:0]  match_pos;

   // Compare every live cell against the addressed slot
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < stq_pkg::SLOTS; i++) begin
         match[i] = (stq_pkg::CNT_W'(i) < count_ff) && (entry_ff[i] == cmd.id);
         if (match[i]) begin
            match_pos = match_pos | stq_pkg::ID_W'(i);
         end
      end
   end

   // Cell chain: find, close a gap, open a gap, compact, set length
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      hit_in = hit_ff;
      pos_in = pos_ff;
      case (cmd.op)
         stq_pkg::LST_FIND: begin
            hit_in = |match;
            pos_in = match_pos;
         end
         stq_pkg::LST_REMOVE: begin
            if (hit_ff) begin
               for (int i = 0; i < stq_pkg::SLOTS - 1; i++) begin
                  if (stq_pkg::ID_W'(i) >= pos_ff) begin
                     entry_in[i] = entry_ff[i+1];
                  end
               end
               count_in = count_ff - stq_pkg::CNT_W'(1);
            end
         end
         stq_pkg::LST_INSERT: begin
            if (cmd.idx == '0) begin
               entry_in[0] = cmd.id;
            end
            for (int i = 1; i < stq_pkg::SLOTS; i++) begin
               if (stq_pkg::CNT_W'(i) > cmd.idx) begin
                  entry_in[i] = entry_ff[i-1];
               end else if (stq_pkg::CNT_W'(i) == cmd.idx) begin
                  entry_in[i] = cmd.id;
               end
            end
            count_in = count_ff + stq_pkg::CNT_W'(1);
         end
         stq_pkg::LST_WRITE: begin
            entry_in[cmd.idx[stq_pkg::ID_W-1:0]] = cmd.id;
         end
         stq_pkg::LST_COUNT: begin
            count_in = cmd.idx;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      entry_ff <= entry_in;
   end

   assign rd_id = entry_ff[rd_idx];
   assign stat.hit = hit_ff;
   assign stat.count = count_ff;

   // Checks on the list itself
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stq_pkg::CNT_W'(stq_pkg::SLOTS))
      else $error("pending count beyond slot count");

   a_unique_ids: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == stq_pkg::LST_FIND) |-> $onehot0(match))
      else $error("slot listed more than once");

   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == stq_pkg::LST_REMOVE && hit_ff) |-> (count_ff != '0))
      else $error("removal from an empty list");

endmodule

FILE: src/sorted_timer_event_queue.sv
// Channel  Dir  Handshake                Payload
// req      in   req_tvalid / req_tready  tdata: event_id, clock_value; tuser: op, abs, ms
// rsp      out  rsp_tvalid / rsp_tready  tdata: fired_id .. window_left; tuser: fired; tlast
// csr      in   csr_wr_en                csr_index, csr_wdata (no read-back)
//
// One operation at a time; req_tready is high only between operations.
// Set scans the list entry by entry for its place through the one due-time read
// port; progress walks every pending slot twice and emits a beat per fired slot.
// A finished beat waits in the output register while the next request is taken;
// a stalled rsp side holds the sequencer only when it has another beat to load.
// Synchronous reset empties the list and clears the window; due times are not reset.
module sorted_timer_event_queue (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // event_id[4:0], clock_value[36:5], zero pad
   input  logic [4:0]    req_tuser,   // operation[2:0], absolute[3], in_ms[4]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // fired_id[4:0], active[5], remaining[37:6],
                                      // window_base[69:38], window_left[101:70], pad
   output logic [0:0]    rsp_tuser,   // fired[0]
   output logic          rsp_tlast,
   input  logic          csr_wr_en,
   input  logic [0:0]    csr_index,
   input  logic [30:0]   csr_wdata
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] S_SET_DLY  = 5'd1;
   localparam logic [ST_W-1:0] S_SET_DUE  = 5'd2;
   localparam logic [ST_W-1:0] S_SET_ADD  = 5'd3;
   localparam logic [ST_W-1:0] S_SET_WR   = 5'd4;
   localparam logic [ST_W-1:0] S_SCAN_A   = 5'd5;
   localparam logic [ST_W-1:0] S_SCAN_B   = 5'd6;
   localparam logic [ST_W-1:0] S_INS      = 5'd7;
   localparam logic [ST_W-1:0] S_HEAD1    = 5'd8;
   localparam logic [ST_W-1:0] S_HEAD2    = 5'd9;
   localparam logic [ST_W-1:0] S_FIND     = 5'd10;
   localparam logic [ST_W-1:0] S_REMOVE   = 5'd11;
   localparam logic [ST_W-1:0] S_Q1       = 5'd12;
   localparam logic [ST_W-1:0] S_Q2       = 5'd13;
   localparam logic [ST_W-1:0] S_Q3       = 5'd14;
   localparam logic [ST_W-1:0] S_CONS     = 5'd15;
   localparam logic [ST_W-1:0] S_FORCE    = 5'd16;
   localparam logic [ST_W-1:0] S_P1A      = 5'd17;
   localparam logic [ST_W-1:0] S_P1B      = 5'd18;
   localparam logic [ST_W-1:0] S_P1C      = 5'd19;
   localparam logic [ST_W-1:0] S_P1END    = 5'd20;
   localparam logic [ST_W-1:0] S_P2A      = 5'd21;
   localparam logic [ST_W-1:0] S_P2B      = 5'd22;
   localparam logic [ST_W-1:0] S_P2EMIT   = 5'd23;
   localparam logic [ST_W-1:0] S_P2END    = 5'd24;
   localparam logic [ST_W-1:0] S_DONE     = 5'd25;

   localparam int DW = stq_pkg::DATA_W;
   localparam int IW = stq_pkg::ID_W;
   localparam int CW = stq_pkg::CNT_W;

   // Request fields
   logic [2:0]    req_op;
   logic [IW-1:0] req_id;
   logic [DW-1:0] req_val;
   assign req_op = req_tuser[2:0];
   assign req_id = req_tdata[4:0];
   assign req_val = req_tdata[36:5];

   logic [ST_W-1:0] state_ff, state_in;
   logic [IW-1:0] id_ff, id_in;
   logic [DW-1:0] val_ff, val_in;
   logic abs_ff, abs_in, ms_ff, ms_in;
   logic [DW-1:0] wl_ff, wl_in, wr_ff, wr_in;
   logic [stq_pkg::CFG_W-1:0] max_win_ff, max_win_in, cpm_ff, cpm_in;
   logic [DW-1:0] delay_ff, delay_in, tmp_ff, tmp_in, due_ff, due_in;
   logic [DW-1:0] nb_ff, nb_in, oldwl_ff, oldwl_in, d_ff, d_in;
   logic [CW-1:0] i_ff, i_in, kept_ff, kept_in, fcnt_ff, fcnt_in, femit_ff, femit_in;
   logic [IW-1:0] cur_id_ff, cur_id_in, fid_ff, fid_in;
   logic act_ff, act_in;
   logic [DW-1:0] rem_ff, rem_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] r_fid_ff, r_fid_in;
   logic r_fired_ff, r_fired_in, r_act_ff, r_act_in, r_last_ff, r_last_in;
   logic [DW-1:0] r_rem_ff, r_rem_in, r_wb_ff, r_wb_in, r_wl_ff, r_wl_in;

   // Shared unit, due-time store and order list
   logic [1:0] alu_op;
   logic [DW-1:0] alu_a, alu_b, alu_y;
   logic alu_lt;
   logic mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;
   stq_pkg::lst_cmd_type lst_cmd;
   stq_pkg::lst_stat_type lst_stat;
   logic [IW-1:0] lst_rd_id;

   logic out_free, y_pos, d_pos, wr_pos, req_take;

   stq_alu u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_y),
      .less   (alu_lt)
   );

   stq_due_mem u_due_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   stq_list u_list (
      .clock  (clock),
      .reset  (reset),
      .cmd    (lst_cmd),
      .rd_idx (i_ff[IW-1:0]),
      .rd_id  (lst_rd_id),
      .stat   (lst_stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign y_pos = !alu_y[DW-1] && (alu_y != '0);
   assign d_pos = !d_ff[DW-1] && (d_ff != '0);
   assign wr_pos = !wr_ff[DW-1] && (wr_ff != '0);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      id_in = id_ff;
      val_in = val_ff;
      abs_in = abs_ff;
      ms_in = ms_ff;
      wl_in = wl_ff;
      wr_in = wr_ff;
      max_win_in = max_win_ff;
      cpm_in = cpm_ff;
      delay_in = delay_ff;
      tmp_in = tmp_ff;
      due_in = due_ff;
      nb_in = nb_ff;
      oldwl_in = oldwl_ff;
      d_in = d_ff;
      i_in = i_ff;
      kept_in = kept_ff;
      fcnt_in = fcnt_ff;
      femit_in = femit_ff;
      cur_id_in = cur_id_ff;
      fid_in = fid_ff;
      act_in = act_ff;
      rem_in = rem_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      r_fid_in = r_fid_ff;
      r_fired_in = r_fired_ff;
      r_act_in = r_act_ff;
      r_rem_in = r_rem_ff;
      r_wb_in = r_wb_ff;
      r_wl_in = r_wl_ff;
      r_last_in = r_last_ff;

      alu_op = stq_pkg::ALU_ADD;
      alu_a = '0;
      alu_b = '0;
      mem_we = 1'b0;
      mem_waddr = id_ff;
      mem_wdata = due_ff;
      mem_re = 1'b0;
      mem_raddr = id_ff;
      lst_cmd.op = stq_pkg::LST_NOP;
      lst_cmd.id = id_ff;
      lst_cmd.idx = i_ff;

      // Take configuration writes at any time
      if (csr_wr_en) begin
         case (csr_index[0])
            stq_pkg::REG_MAX_WINDOW:    max_win_in = csr_wdata;
            stq_pkg::REG_CLOCKS_PER_MS: cpm_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               id_in = req_id;
               val_in = req_val;
               abs_in = req_tuser[3];
               ms_in = req_tuser[4];
               fid_in = (req_op == stq_pkg::OP_QUERY) ? req_id : '0;
               act_in = 1'b0;
               rem_in = '0;
               i_in = '0;
               case (req_op)
                  stq_pkg::OP_SET:       state_in = S_SET_DLY;
                  stq_pkg::OP_CANCEL:    state_in = S_FIND;
                  stq_pkg::OP_QUERY:     state_in = S_Q1;
                  stq_pkg::OP_CONSUME:   state_in = S_CONS;
                  stq_pkg::OP_FORCE_EXIT: state_in = S_FORCE;
                  stq_pkg::OP_PROGRESS: begin
                     nb_in = {1'b0, max_win_ff};
                     oldwl_in = wl_ff;
                     fcnt_in = '0;
                     state_in = S_P1A;
                  end
                  default:               state_in = S_DONE;
               endcase
            end
         end

         // Set: scale the delay, fetch the old due time, drop the slot
         S_SET_DLY: begin
            alu_op = stq_pkg::ALU_MUL;
            alu_a = {1'b0, cpm_ff};
            alu_b = val_ff;
            delay_in = ms_ff ? alu_y : val_ff;
            mem_re = 1'b1;
            lst_cmd.op = stq_pkg::LST_FIND;
            state_in = S_SET_DUE;
         end
         S_SET_DUE: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = wl_ff;
            alu_b = wr_ff;
            tmp_in = abs_ff ? alu_y : mem_rdata;
            lst_cmd.op = stq_pkg::LST_REMOVE;
            state_in = S_SET_ADD;
         end
         S_SET_ADD: begin
            alu_op = stq_pkg::ALU_ADD;
            alu_a = tmp_ff;
            alu_b = delay_ff;
            due_in = alu_y;
            state_in = S_SET_WR;
         end
         S_SET_WR: begin
            mem_we = 1'b1;
            i_in = '0;
            state_in = (lst_stat.count >= CW'(stq_pkg::SLOTS)) ? S_DONE : S_SCAN_A;
         end

         // Walk the list for the first later due time
         S_SCAN_A: begin
            if (i_ff == lst_stat.count) begin
               state_in = S_INS;
            end else begin
               mem_re = 1'b1;
               mem_raddr = lst_rd_id;
               state_in = S_SCAN_B;
            end
         end
         S_SCAN_B: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = due_ff;
            alu_b = mem_rdata;
            if (alu_lt) begin
               state_in = S_INS;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = S_SCAN_A;
            end
         end
         S_INS: begin
            lst_cmd.op = stq_pkg::LST_INSERT;
            state_in = (i_ff == '0) ? S_HEAD1 : S_DONE;
         end

         // New head: shrink the window to the new due time
         S_HEAD1: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = wr_ff;
            alu_b = wl_ff;
            tmp_in = alu_y;
            state_in = S_HEAD2;
         end
         S_HEAD2: begin
            alu_op = stq_pkg::ALU_ADD;
            alu_a = tmp_ff;
            alu_b = due_ff;
            wr_in = alu_y;
            wl_in = due_ff;
            state_in = S_DONE;
         end

         // Cancel
         S_FIND: begin
            lst_cmd.op = stq_pkg::LST_FIND;
            state_in = S_REMOVE;
         end
         S_REMOVE: begin
            lst_cmd.op = stq_pkg::LST_REMOVE;
            state_in = S_DONE;
         end

         // Query: due time less elapsed clocks
         S_Q1: begin
            lst_cmd.op = stq_pkg::LST_FIND;
            mem_re = 1'b1;
            state_in = S_Q2;
         end
         S_Q2: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = wl_ff;
            alu_b = wr_ff;
            tmp_in = alu_y;
            state_in = S_Q3;
         end
         S_Q3: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = mem_rdata;
            alu_b = tmp_ff;
            act_in = lst_stat.hit;
            rem_in = lst_stat.hit ? alu_y : '1;
            state_in = S_DONE;
         end

         S_CONS: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = wr_ff;
            alu_b = val_ff;
            wr_in = alu_y;
            state_in = S_DONE;
         end
         S_FORCE: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = wl_ff;
            alu_b = wr_ff;
            if (wr_pos) begin
               wl_in = alu_y;
               wr_in = '0;
            end
            state_in = S_DONE;
         end

         // Progress, first pass: next window and number of expiries
         S_P1A: begin
            if (i_ff == lst_stat.count) begin
               state_in = S_P1END;
            end else begin
               mem_re = 1'b1;
               mem_raddr = lst_rd_id;
               state_in = S_P1B;
            end
         end
         S_P1B: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = mem_rdata;
            alu_b = oldwl_ff;
            d_in = alu_y;
            state_in = S_P1C;
         end
         S_P1C: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = nb_ff;
            alu_b = d_ff;
            if (d_pos) begin
               if (!alu_lt) begin
                  nb_in = d_ff;
               end
            end else begin
               fcnt_in = fcnt_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
            state_in = S_P1A;
         end
         S_P1END: begin
            alu_op = stq_pkg::ALU_ADD;
            alu_a = wr_ff;
            alu_b = nb_ff;
            wr_in = alu_y;
            wl_in = nb_ff;
            i_in = '0;
            kept_in = '0;
            femit_in = '0;
            state_in = S_P2A;
         end

         // Progress, second pass: rebase, compact, report expiries
         S_P2A: begin
            if (i_ff == lst_stat.count) begin
               state_in = S_P2END;
            end else begin
               mem_re = 1'b1;
               mem_raddr = lst_rd_id;
               cur_id_in = lst_rd_id;
               state_in = S_P2B;
            end
         end
         S_P2B: begin
            alu_op = stq_pkg::ALU_SUB;
            alu_a = mem_rdata;
            alu_b = oldwl_ff;
            mem_we = 1'b1;
            mem_waddr = cur_id_ff;
            mem_wdata = alu_y;
            if (y_pos) begin
               lst_cmd.op = stq_pkg::LST_WRITE;
               lst_cmd.id = cur_id_ff;
               lst_cmd.idx = kept_ff;
               kept_in = kept_ff + CW'(1);
               i_in = i_ff + CW'(1);
               state_in = S_P2A;
            end else begin
               state_in = S_P2EMIT;
            end
         end
         S_P2EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               r_fid_in = cur_id_ff;
               r_fired_in = 1'b1;
               r_act_in = 1'b0;
               r_rem_in = '0;
               r_wb_in = wl_ff;
               r_wl_in = wr_ff;
               r_last_in = ((femit_ff + CW'(1)) == fcnt_ff);
               femit_in = femit_ff + CW'(1);
               i_in = i_ff + CW'(1);
               state_in = S_P2A;
            end
         end
         S_P2END: begin
            lst_cmd.op = stq_pkg::LST_COUNT;
            lst_cmd.idx = kept_ff;
            state_in = (fcnt_ff == '0) ? S_DONE : S_IDLE;
         end

         // Single closing beat
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               r_fid_in = fid_ff;
               r_fired_in = 1'b0;
               r_act_in = act_ff;
               r_rem_in = rem_ff;
               r_wb_in = wl_ff;
               r_wl_in = wr_ff;
               r_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wl_ff <= '0;
         wr_ff <= '0;
         max_win_ff <= stq_pkg::MAX_WINDOW_RESET;
         cpm_ff <= stq_pkg::CLOCKS_PER_MS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wl_ff <= wl_in;
         wr_ff <= wr_in;
         max_win_ff <= max_win_in;
         cpm_ff <= cpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      id_ff <= id_in;
      val_ff <= val_in;
      abs_ff <= abs_in;
      ms_ff <= ms_in;
      delay_ff <= delay_in;
      tmp_ff <= tmp_in;
      due_ff <= due_in;
      nb_ff <= nb_in;
      oldwl_ff <= oldwl_in;
      d_ff <= d_in;
      i_ff <= i_in;
      kept_ff <= kept_in;
      fcnt_ff <= fcnt_in;
      femit_ff <= femit_in;
      cur_id_ff <= cur_id_in;
      fid_ff <= fid_in;
      act_ff <= act_in;
      rem_ff <= rem_in;
      r_fid_ff <= r_fid_in;
      r_fired_ff <= r_fired_in;
      r_act_ff <= r_act_in;
      r_rem_ff <= r_rem_in;
      r_wb_ff <= r_wb_in;
      r_wl_ff <= r_wl_in;
      r_last_ff <= r_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, r_wl_ff, r_wb_ff, r_rem_ff, r_act_ff, r_fid_ff};
   assign rsp_tuser = r_fired_ff;
   assign rsp_tlast = r_last_ff;

   // A beat that is not the last of its run only comes from the second progress pass
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !r_last_ff) |-> (state_ff == S_P2A || state_ff == S_P2B ||
                                        state_ff == S_P2EMIT || state_ff == S_P2END))
      else $error("open beat run outside progress");

endmodule
